[rtl/core/tbot_pkg.sv]
// Shared constants and types for the triangle/box overlap block.
// No dependencies; imported by every module of the block.
package tbot_pkg;

    // Default coordinate width (signed Q.8 fixed point).
    localparam int COORD_BITS_DEF = 24;

    // Number of coordinate fields in one triangle item.
    localparam int NUM_FIELDS = 9;

    // Result channel data width (one flag padded to a byte).
    localparam int OUT_BYTES_BITS = 8;

    // Configuration register indexes.
    localparam int REG_IDX_BITS = 3;
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_HALF_X   = 3'd3,
        REG_HALF_Y   = 3'd4,
        REG_HALF_Z   = 3'd5
    } reg_index_t;

    // Cyclic neighbors of an axis index (x -> y -> z -> x).
    function automatic int axis_next(input int j);
        return (j == 2) ? 0 : j + 1;
    endfunction

    function automatic int axis_prev(input int j);
        return (j == 0) ? 2 : j - 1;
    endfunction

endpackage

[rtl/core/tbot_front.sv]
// Front stage: accepts triangles, moves them into box-relative space, forms edges.
// Depends on tbot_pkg.
module tbot_front
    import tbot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int VW = COORD_BITS + 1,
    localparam int EW = COORD_BITS + 2,
    localparam int ITEM_BITS = NUM_FIELDS * (VW + EW)
) (
    input  logic                         clk,
    input  logic                         rstn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [NUM_FIELDS*COORD_BITS-1:0] s_data,
    input  logic signed [COORD_BITS-1:0] center [3],
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [ITEM_BITS-1:0]         q_data
);

    logic signed [VW-1:0] vt [3][3];
    logic signed [EW-1:0] e  [3][3];
    logic [ITEM_BITS-1:0] item_next;
    logic [ITEM_BITS-1:0] item_reg;
    logic                 valid_reg;
    logic                 go;

    // Each vertex minus the box center, then the triangle's edges, packed into the item.
    always_comb begin
        logic signed [COORD_BITS-1:0] v;
        item_next = '0;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                v = s_data[(k*3+i)*COORD_BITS +: COORD_BITS];
                vt[k][i] = $signed({v[COORD_BITS-1], v})
                         - $signed({center[i][COORD_BITS-1], center[i]});
            end
        end
        for (int i = 0; i < 3; i++) begin
            e[0][i] = vt[1][i] - vt[0][i];
            e[1][i] = vt[2][i] - vt[1][i];
            e[2][i] = vt[0][i] - vt[2][i];
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                item_next[(k*3+i)*VW +: VW] = vt[k][i];
                item_next[NUM_FIELDS*VW + (k*3+i)*EW +: EW] = e[k][i];
            end
        end
    end

    // The stage takes a new item whenever it is empty or its item moves on.
    assign go      = !valid_reg || q_ready;
    assign s_ready = go;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= 1'b0;
        end else if (go) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (go) begin
            item_reg <= item_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = item_reg;

endmodule

[rtl/core/tbot_queue.sv]
// Two-entry register queue between the front and back stages.
// Depends on tbot_pkg only through the common import convention.
module tbot_queue
    import tbot_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_BITS-1:0] in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DATA_BITS-1:0] out_data
);

    logic [DATA_BITS-1:0] slot_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg,  count_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/core/tbot_back.sv]
// Back pipeline: five stages that run the 13 separating-axis tests exactly.
// Depends on tbot_pkg.
module tbot_back
    import tbot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int VW = COORD_BITS + 1,
    localparam int EW = COORD_BITS + 2,
    localparam int HW = COORD_BITS - 1,
    localparam int ITEM_BITS = NUM_FIELDS * (VW + EW)
) (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [ITEM_BITS-1:0] q_data,
    input  logic [HW-1:0]        half [3],
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_overlap
);

    localparam int PW  = EW + VW;          // edge-axis product
    localparam int RW  = HW + EW;          // edge-axis radius term
    localparam int CW2 = PW + 2;           // edge-axis compare width
    localparam int FW  = VW + 1;           // face compare width
    localparam int NW  = 2 * EW + 1;       // normal component
    localparam int SPL = EW + 1;           // split point of a normal component
    localparam int NHW = NW - SPL;         // upper part width
    localparam int PLW = SPL + 1 + VW;     // lower partial product
    localparam int PHW = NHW + VW;         // upper partial product
    localparam int RLW = HW + SPL;
    localparam int RHW = HW + NHW;
    localparam int FPW = NW + VW;          // full normal product
    localparam int DW  = FPW + 2;          // normal projection
    localparam int RNW = HW + NW + 2;      // normal radius
    localparam int CW5 = DW + 1;           // normal compare width

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // The whole pipeline moves unless a finished result is waiting.
    assign en      = !v5_reg || m_ready;
    assign q_ready = en;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ---------------- Stage 1: all first-level products ----------------
    logic signed [VW-1:0] vt0 [3][3];
    logic signed [EW-1:0] e0  [3][3];
    logic        [EW-1:0] ae  [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                vt0[k][i] = q_data[(k*3+i)*VW +: VW];
                e0[k][i]  = q_data[NUM_FIELDS*VW + (k*3+i)*EW +: EW];
                ae[k][i]  = e0[k][i][EW-1] ? (~e0[k][i] + 1'b1) : e0[k][i];
            end
        end
    end

    logic signed [PW-1:0] pa_reg [3][3][2];
    logic signed [PW-1:0] pb_reg [3][3][2];
    logic        [RW-1:0] ra_reg [3][3];
    logic        [RW-1:0] rb_reg [3][3];
    logic signed [2*EW-1:0] nc_reg [3][2];
    logic signed [VW-1:0] vt1_reg [3][3];

    // An edge's own two endpoints project alike, so two vertices suffice per axis.
    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int m = 0; m < 2; m++) begin
                        pa_reg[k][j][m] <= e0[k][axis_prev(j)]
                            * vt0[(m == 0) ? 0 : ((k == 0) ? 2 : 1)][axis_next(j)];
                        pb_reg[k][j][m] <= e0[k][axis_next(j)]
                            * vt0[(m == 0) ? 0 : ((k == 0) ? 2 : 1)][axis_prev(j)];
                    end
                    ra_reg[k][j] <= half[axis_next(j)] * ae[k][axis_prev(j)];
                    rb_reg[k][j] <= half[axis_prev(j)] * ae[k][axis_next(j)];
                end
            end
            for (int i = 0; i < 3; i++) begin
                nc_reg[i][0] <= e0[0][axis_next(i)] * e0[1][axis_prev(i)];
                nc_reg[i][1] <= e0[0][axis_prev(i)] * e0[1][axis_next(i)];
            end
            vt1_reg <= vt0;
        end
    end

    // ---------------- Stage 2: edge and face tests, normal ----------------
    logic edge_sep [3][3];
    logic face_sep [3];
    logic early2;

    always_comb begin
        logic signed [CW2-1:0] p0, p1, sr;
        logic signed [FW-1:0]  f0, f1, f2, hs;
        early2 = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                p0 = pa_reg[k][j][0];
                p0 = p0 - pb_reg[k][j][0];
                p1 = pa_reg[k][j][1];
                p1 = p1 - pb_reg[k][j][1];
                sr = $signed({2'b00, ra_reg[k][j]}) + $signed({2'b00, rb_reg[k][j]});
                edge_sep[k][j] = (p0 > sr && p1 > sr) || (p0 < -sr && p1 < -sr);
                early2 = early2 | edge_sep[k][j];
            end
        end
        for (int j = 0; j < 3; j++) begin
            f0 = vt1_reg[0][j];
            f1 = vt1_reg[1][j];
            f2 = vt1_reg[2][j];
            hs = $signed({1'b0, half[j]});
            face_sep[j] = (f0 > hs && f1 > hs && f2 > hs)
                       || (f0 < -hs && f1 < -hs && f2 < -hs);
            early2 = early2 | face_sep[j];
        end
    end

    logic signed [NW-1:0] n2_reg [3];
    logic signed [VW-1:0] vt2_reg [3][3];
    logic                 early2_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n2_reg[i] <= nc_reg[i][0] - nc_reg[i][1];
            end
            vt2_reg    <= vt1_reg;
            early2_reg <= early2;
        end
    end

    // ---------------- Stage 3: split normal products ----------------
    logic [NW-1:0] an [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            an[i] = n2_reg[i][NW-1] ? (~n2_reg[i] + 1'b1) : n2_reg[i];
        end
    end

    logic signed [PLW-1:0] pl_reg [3][3];
    logic signed [PHW-1:0] ph_reg [3][3];
    logic        [RLW-1:0] rl_reg [3];
    logic        [RHW-1:0] rh_reg [3];
    logic                  early3_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    pl_reg[k][i] <= $signed({1'b0, n2_reg[i][SPL-1:0]}) * vt2_reg[k][i];
                    ph_reg[k][i] <= $signed(n2_reg[i][NW-1:SPL]) * vt2_reg[k][i];
                end
            end
            for (int i = 0; i < 3; i++) begin
                rl_reg[i] <= half[i] * an[i][SPL-1:0];
                rh_reg[i] <= half[i] * an[i][NW-1:SPL];
            end
            early3_reg <= early2_reg;
        end
    end

    // ---------------- Stage 4: recombine and sum normal projections ----------------
    logic signed [DW-1:0] pn [3];
    logic        [RNW-1:0] rn;

    always_comb begin
        logic signed [FPW-1:0] fp;
        logic [HW+NW-1:0]      fr;
        rn = '0;
        for (int k = 0; k < 3; k++) begin
            pn[k] = '0;
            for (int i = 0; i < 3; i++) begin
                fp = $signed({ph_reg[k][i], {SPL{1'b0}}}) + pl_reg[k][i];
                pn[k] = pn[k] + fp;
            end
        end
        for (int i = 0; i < 3; i++) begin
            fr = {rh_reg[i], {SPL{1'b0}}} + (HW+NW)'(rl_reg[i]);
            rn = rn + (RNW)'(fr);
        end
    end

    logic signed [DW-1:0]  p4_reg [3];
    logic        [RNW-1:0] r4_reg;
    logic                  early4_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            p4_reg     <= pn;
            r4_reg     <= rn;
            early4_reg <= early3_reg;
        end
    end

    // ---------------- Stage 5: normal test and result register ----------------
    logic overlap_next;
    logic overlap_reg;

    always_comb begin
        logic signed [CW5-1:0] q0, q1, q2, sr;
        q0 = p4_reg[0];
        q1 = p4_reg[1];
        q2 = p4_reg[2];
        sr = $signed({1'b0, r4_reg});
        overlap_next = !(early4_reg
                      || (q0 > sr && q1 > sr && q2 > sr)
                      || (q0 < -sr && q1 < -sr && q2 < -sr));
    end

    always_ff @(posedge clk) begin
        if (en) begin
            overlap_reg <= overlap_next;
        end
    end

    assign m_valid   = v5_reg;
    assign m_overlap = overlap_reg;

endmodule

[rtl/core/triangle_box_overlap_test.sv]
// Top level of the triangle versus box overlap block: registers, front, queue, back.
// Depends on tbot_pkg, tbot_front, tbot_queue and tbot_back.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_tvalid/s_tready  | one triangle, nine coordinates
//  m_      | out       | m_tvalid/m_tready  | overlap flag
//  cfg_    | in        | cfg_we             | box center and half-extents
//
// One triangle is accepted per cycle while s_tready is high; the flag becomes
// valid once the item has passed the front register, a queue slot and the five
// back stages.
// Reset clears all valid bits and the queue; box registers reset to zero.
// A stalled result holds the back pipeline; the front and the two-entry queue
// keep taking items until the queue fills, up to eight items in flight.
module triangle_box_overlap_test
    import tbot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_BITS  = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8,
    localparam int ITEM_BITS = NUM_FIELDS * (2 * COORD_BITS + 3)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z
    input  logic [IN_BITS-1:0]        s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // overlap
    output logic [OUT_BYTES_BITS-1:0] m_tdata,
    input  logic                      cfg_we,
    input  logic [REG_IDX_BITS-1:0]   cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_wdata
);

    logic signed [COORD_BITS-1:0] center_reg [3];
    logic        [COORD_BITS-2:0] half_reg   [3];

    // Box registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                center_reg[i] <= '0;
                half_reg[i]   <= '0;
            end
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_CENTER_X: center_reg[0] <= cfg_wdata;
                REG_CENTER_Y: center_reg[1] <= cfg_wdata;
                REG_CENTER_Z: center_reg[2] <= cfg_wdata;
                REG_HALF_X:   half_reg[0]   <= cfg_wdata[COORD_BITS-2:0];
                REG_HALF_Y:   half_reg[1]   <= cfg_wdata[COORD_BITS-2:0];
                REG_HALF_Z:   half_reg[2]   <= cfg_wdata[COORD_BITS-2:0];
                default: ;
            endcase
        end
    end

    logic                 fq_valid, fq_ready;
    logic [ITEM_BITS-1:0] fq_data;
    logic                 qb_valid, qb_ready;
    logic [ITEM_BITS-1:0] qb_data;
    logic                 overlap;

    tbot_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk     (aclk),
        .rstn    (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_data  (s_tdata[NUM_FIELDS*COORD_BITS-1:0]),
        .center  (center_reg),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    tbot_queue #(.DATA_BITS(ITEM_BITS)) u_queue (
        .clk       (aclk),
        .rstn      (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    tbot_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk       (aclk),
        .rstn      (aresetn),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .half      (half_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_overlap (overlap)
    );

    assign m_tdata = {{(OUT_BYTES_BITS-1){1'b0}}, overlap};

endmodule

[rtl/core/tbot_checker.sv]
// Port-level checks for the triangle/box overlap block, bound to its top level.
// Depends on tbot_pkg and triangle_box_overlap_test.
module tbot_checker
    import tbot_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_BYTES_BITS-1:0] m_tdata
);

    logic       in_acc, out_acc;
    logic [3:0] inflight_reg, inflight_next;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Items accepted but not yet delivered.
    always_comb begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc) begin
            inflight_next = inflight_reg + 4'd1;
        end else if (out_acc && !in_acc) begin
            inflight_next = inflight_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= 4'd0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result without an item behind it.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == 4'd0 |-> !m_tvalid)
        else $error("result without a pending item");

    // Buffering is bounded by the front register, queue and back stages.
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 4'd8)
        else $error("too many items in flight");

    // Pad bits of the result stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_BYTES_BITS-1:1] == '0)
        else $error("nonzero pad bits in result");

endmodule

bind triangle_box_overlap_test tbot_checker u_tbot_checker (.*);
